### sv/tftg_pkg.sv
`default_nettype none
package tftg_pkg;

   // Fixed geometry and field widths
   localparam int LEG_COUNT = 4;
   localparam int LEG_W     = 2;
   localparam int CFG_W     = 10;

   // Register indexes on the configuration port
   localparam logic [0:0] CSR_CYCLE  = 1'b0;
   localparam logic [0:0] CSR_STANCE = 1'b1;

   // Reset values
   localparam logic [CFG_W-1:0] CYCLE_RESET  = 10'd160;
   localparam logic [CFG_W-1:0] STANCE_RESET = 10'd96;
   localparam logic [CFG_W-1:0] GAIT_RESET   = 10'd48;

   // Q30 constants
   localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
   localparam logic signed [31:0] HALF_Q30   = 32'sd536870912;
   localparam logic signed [31:0] INV2PI_Q30 = 32'sd170891319;
   localparam longint unsigned    HALFPI_Q30 = 64'd1686629713;

   // Foot position limits in micrometers
   localparam logic signed [23:0] XY_MAX = 24'sd200000;
   localparam logic signed [23:0] XY_MIN = -24'sd200000;
   localparam logic signed [23:0] Z_MAX  = 24'sd0;
   localparam logic signed [23:0] Z_MIN  = -24'sd400000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_DIV,
      ST_G_CAP,
      ST_LEG_SET,
      ST_U_DIV,
      ST_TAB_RD,
      ST_QUAD,
      ST_MUL,
      ST_WB,
      ST_SUM,
      ST_OUT
   } state_type;

   // One multiply-and-round operation per code
   typedef enum logic [2:0] {
      MOP_CYC,
      MOP_DX,
      MOP_DY,
      MOP_YD,
      MOP_TX,
      MOP_TY,
      MOP_LZ
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       g_cap;
      logic       leg_start;
      logic       tab_rd;
      logic       quad;
      logic       mul_go;
      logic       mul_wb;
      mul_op_type mul_op;
      logic       sum;
      logic       leg_next;
      logic       tick_done;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_pending;
      logic leg_last;
   } status_type;

   // Operation that follows a given one in the per-leg sequence
   function automatic mul_op_type next_op(input mul_op_type op);
      mul_op_type r;
      case (op)
         MOP_CYC: r = MOP_DX;
         MOP_DX:  r = MOP_DY;
         MOP_DY:  r = MOP_YD;
         MOP_YD:  r = MOP_TX;
         MOP_TX:  r = MOP_TY;
         MOP_TY:  r = MOP_LZ;
         default: r = MOP_CYC;
      endcase
      return r;
   endfunction

   // Legs 1 and 2 run half a period behind legs 0 and 3.
   function automatic logic leg_half(input logic [LEG_W-1:0] leg);
      return (leg == 2'd1) || (leg == 2'd2);
   endfunction

   function automatic logic signed [17:0] leg_base_x(input logic [LEG_W-1:0] leg);
      return leg[1] ? -18'sd90000 : 18'sd60000;
   endfunction

   function automatic logic signed [17:0] leg_base_y(input logic [LEG_W-1:0] leg);
      return leg[0] ? -18'sd82000 : 18'sd82000;
   endfunction

   function automatic logic signed [17:0] leg_tan_x(input logic [LEG_W-1:0] leg);
      logic signed [17:0] r;
      case (leg)
         2'd0:    r = -18'sd33255;
         2'd1:    r = 18'sd33255;
         2'd2:    r = -18'sd30690;
         default: r = 18'sd30690;
      endcase
      return r;
   endfunction

   function automatic logic signed [17:0] leg_tan_y(input logic [LEG_W-1:0] leg);
      return leg[1] ? -18'sd57905 : 18'sd56472;
   endfunction

   // Sine over the first quadrant, truncating Q30 series
   function automatic logic [30:0] sin_entry(input int unsigned r, input int unsigned qb);
      longint unsigned one;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      one = 64'd1 << 30;
      x   = (longint'(r) * HALFPI_Q30) >> qb;
      x2  = (x * x) >> 30;
      t   = one - x2 / 110;
      t   = one - ((x2 * t) >> 30) / 72;
      t   = one - ((x2 * t) >> 30) / 42;
      t   = one - ((x2 * t) >> 30) / 20;
      t   = one - ((x2 * t) >> 30) / 6;
      s   = (x * t) >> 30;
      return s[30:0];
   endfunction

   // Cosine over the first quadrant, truncating Q30 series
   function automatic logic [30:0] cos_entry(input int unsigned r, input int unsigned qb);
      longint unsigned one;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned c;
      one = 64'd1 << 30;
      x   = (longint'(r) * HALFPI_Q30) >> qb;
      x2  = (x * x) >> 30;
      t   = one - x2 / 132;
      t   = one - ((x2 * t) >> 30) / 90;
      t   = one - ((x2 * t) >> 30) / 56;
      t   = one - ((x2 * t) >> 30) / 30;
      t   = one - ((x2 * t) >> 30) / 12;
      c   = one - ((x2 * t) >> 30) / 2;
      return c[30:0];
   endfunction

endpackage
`default_nettype wire

### sv/tftg_ctrl.sv
`default_nettype none
module tftg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire tftg_pkg::status_type status,
   output tftg_pkg::cmd_type        cmd
);
   import tftg_pkg::*;

   state_type  state_ff, state_in;
   mul_op_type op_ff, op_in;

   // State and operation registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= MOP_CYC;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MOD_DIV;
         ST_MOD_DIV: if (status.div_done) state_in = ST_G_CAP;
         ST_G_CAP:   state_in = ST_LEG_SET;
         ST_LEG_SET: state_in = ST_U_DIV;
         ST_U_DIV:   if (status.div_done) state_in = ST_TAB_RD;
         ST_TAB_RD:  state_in = ST_QUAD;
         ST_QUAD: begin
            state_in = ST_MUL;
            op_in    = MOP_CYC;
         end
         ST_MUL:     state_in = ST_WB;
         ST_WB: begin
            if (op_ff == MOP_LZ) begin
               state_in = ST_SUM;
            end else begin
               state_in = ST_MUL;
               op_in    = next_op(op_ff);
            end
         end
         ST_SUM:     state_in = ST_OUT;
         ST_OUT: begin
            if (!status.rsp_pending) begin
               state_in = status.leg_last ? ST_IDLE : ST_LEG_SET;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd        = '0;
      cmd.mul_op = op_ff;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_G_CAP:   cmd.g_cap = 1'b1;
         ST_LEG_SET: cmd.leg_start = 1'b1;
         ST_TAB_RD:  cmd.tab_rd = 1'b1;
         ST_QUAD:    cmd.quad = 1'b1;
         ST_MUL:     cmd.mul_go = 1'b1;
         ST_WB:      cmd.mul_wb = 1'b1;
         ST_SUM:     cmd.sum = 1'b1;
         ST_OUT: begin
            if (!status.rsp_pending) begin
               cmd.leg_next  = !status.leg_last;
               cmd.tick_done = status.leg_last;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/tftg_datapath.sv
`default_nettype none
module tftg_datapath #(
   parameter int TABLE_BITS = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [0:0]          csr_index,
   input  wire logic [9:0]          csr_wdata,
   input  wire logic                req_restart,
   input  wire logic signed [18:0]  req_step_fwd,
   input  wire logic signed [16:0]  req_step_lat,
   input  wire logic signed [16:0]  req_yaw_amp,
   input  wire logic signed [19:0]  req_stand_z,
   input  wire logic [16:0]         req_lift_h,
   input  wire tftg_pkg::cmd_type   cmd,
   output tftg_pkg::status_type     status,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_leg,
   output logic signed [18:0]       rsp_foot_x,
   output logic signed [18:0]       rsp_foot_y,
   output logic signed [19:0]       rsp_foot_z,
   output logic                     rsp_in_stance,
   output logic                     rsp_all_stance,
   output logic                     rsp_last
);
   import tftg_pkg::*;

   localparam int QB     = TABLE_BITS - 2;
   localparam int TAB_N  = 1 << QB;
   localparam int QW     = (TABLE_BITS > CFG_W) ? TABLE_BITS : CFG_W;
   localparam int CW     = $clog2(QW + 1);
   localparam int SQ_SH  = 30 - TABLE_BITS;

   // Configuration registers
   logic [CFG_W-1:0] cycle_ff, stance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff  <= CYCLE_RESET;
         stance_ff <= STANCE_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_CYCLE) cycle_ff <= csr_wdata;
         if (csr_index == CSR_STANCE) stance_ff <= csr_wdata;
      end
   end

   // Effective period and stance length
   logic [CFG_W-1:0] c_eff, s_lo, s_eff;
   always_comb begin
      c_eff = (cycle_ff < 10'd2) ? 10'd2 : cycle_ff;
      s_lo  = (stance_ff < 10'd1) ? 10'd1 : stance_ff;
      s_eff = (s_lo > c_eff - 10'd1) ? c_eff - 10'd1 : s_lo;
   end

   // Request capture
   logic signed [18:0] sf_ff;
   logic signed [16:0] sl_ff, yw_ff;
   logic signed [19:0] sz_ff;
   logic [16:0]        lh_ff;
   logic [CFG_W-1:0]   c_ff, s_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sf_ff <= req_step_fwd;
         sl_ff <= req_step_lat;
         yw_ff <= req_yaw_amp;
         sz_ff <= req_stand_z;
         lh_ff <= req_lift_h;
         c_ff  <= c_eff;
         s_ff  <= s_eff;
      end
   end

   // Gait counter
   logic [CFG_W-1:0] gait_ff, g_ff, g_next, gsel;
   assign gsel   = req_restart ? {1'b0, s_eff[CFG_W-1:1]} : gait_ff;
   assign g_next = g_ff + 10'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gait_ff <= GAIT_RESET;
      end else if (cmd.tick_done) begin
         gait_ff <= (g_next == c_ff) ? '0 : g_next;
      end
   end

   // Divider registers and operands
   logic [CFG_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CFG_W:0]   trial;
   logic             ge;
   logic [CFG_W-1:0] cur_p, num_leg, den_leg;
   logic             cur_st;

   // Per-leg phase and stance flags
   logic [CFG_W-1:0] p_ff [LEG_COUNT];
   logic [CFG_W-1:0] p_calc [LEG_COUNT];
   logic [LEG_COUNT-1:0] st_ff, st_calc;
   logic all_ff;
   logic [LEG_W-1:0] leg_ff;

   always_comb begin
      for (int i = 0; i < LEG_COUNT; i++) begin
         logic [CFG_W:0] psum;
         psum = {1'b0, rem_ff} +
                (leg_half(LEG_W'(i)) ? {2'b0, c_ff[CFG_W-1:1]} : 11'd0);
         p_calc[i]  = (psum >= {1'b0, c_ff}) ? CFG_W'(psum - {1'b0, c_ff})
                                             : psum[CFG_W-1:0];
         st_calc[i] = p_calc[i] < s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.g_cap) begin
         g_ff   <= rem_ff;
         p_ff   <= p_calc;
         st_ff  <= st_calc;
         all_ff <= &st_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leg_ff <= '0;
      end else if (cmd.load) begin
         leg_ff <= '0;
      end else if (cmd.leg_next) begin
         leg_ff <= leg_ff + 2'd1;
      end
   end

   // Restoring divider, one quotient bit per cycle
   assign cur_p   = p_ff[leg_ff];
   assign cur_st  = st_ff[leg_ff];
   assign num_leg = cur_st ? cur_p : cur_p - s_ff;
   assign den_leg = cur_st ? s_ff : c_ff - s_ff;
   assign trial   = {rem_ff, q_ff[QW-1]};
   assign ge      = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      den_in = den_ff;
      if (cmd.load) begin
         rem_in = '0;
         q_in   = QW'(gsel) << (QW - CFG_W);
         cnt_in = CW'(CFG_W);
         den_in = c_eff;
      end else if (cmd.leg_start) begin
         rem_in = num_leg;
         q_in   = '0;
         cnt_in = CW'(TABLE_BITS);
         den_in = den_leg;
      end else if (cnt_ff != '0) begin
         rem_in = ge ? CFG_W'(trial - {1'b0, den_ff}) : trial[CFG_W-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   // Quarter-wave sine and cosine tables
   logic [30:0] sin_tab [TAB_N];
   logic [30:0] cos_tab [TAB_N];
   for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
      assign sin_tab[gi] = sin_entry(gi, QB);
      assign cos_tab[gi] = cos_entry(gi, QB);
   end

   logic [TABLE_BITS-1:0] u;
   logic [1:0]            qd_ff;
   logic [30:0]           ts_ff, tc_ff, sq_ff;
   assign u = q_ff[TABLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.tab_rd) begin
         qd_ff <= u[TABLE_BITS-1:QB];
         ts_ff <= sin_tab[u[QB-1:0]];
         tc_ff <= cos_tab[u[QB-1:0]];
         sq_ff <= 31'(u) << SQ_SH;
      end
   end

   // Quadrant unfolding
   logic signed [31:0] sn_ff, cs_ff, ts_s, tc_s, sq_s;
   assign ts_s = signed'({1'b0, ts_ff});
   assign tc_s = signed'({1'b0, tc_ff});
   assign sq_s = signed'({1'b0, sq_ff});

   always_ff @(posedge clock) begin
      if (cmd.quad) begin
         case (qd_ff)
            2'd0: begin
               sn_ff <= ts_s;
               cs_ff <= tc_s;
            end
            2'd1: begin
               sn_ff <= tc_s;
               cs_ff <= -ts_s;
            end
            2'd2: begin
               sn_ff <= -ts_s;
               cs_ff <= -tc_s;
            end
            default: begin
               sn_ff <= -tc_s;
               cs_ff <= ts_s;
            end
         endcase
      end
   end

   // Shared multiplier with operand selection
   logic signed [31:0] cyc_ff, dx_ff, dy_ff, yd_ff, tx_ff, ty_ff, lz_ff;
   logic signed [31:0] frac, op_a, op_b;
   logic signed [32:0] omc;
   logic signed [63:0] prod_ff, prod_in;

   assign frac = cur_st ? HALF_Q30 - sq_s : cyc_ff - HALF_Q30;
   assign omc  = 33'(ONE_Q30) - 33'(cs_ff);

   always_comb begin
      unique case (cmd.mul_op)
         MOP_CYC: begin
            op_a = sn_ff;
            op_b = INV2PI_Q30;
         end
         MOP_DX: begin
            op_a = 32'(sf_ff);
            op_b = frac;
         end
         MOP_DY: begin
            op_a = 32'(sl_ff);
            op_b = frac;
         end
         MOP_YD: begin
            op_a = 32'(yw_ff);
            op_b = frac;
         end
         MOP_TX: begin
            op_a = 32'(leg_tan_x(leg_ff));
            op_b = yd_ff;
         end
         MOP_TY: begin
            op_a = 32'(leg_tan_y(leg_ff));
            op_b = yd_ff;
         end
         MOP_LZ: begin
            op_a = signed'({15'b0, lh_ff});
            op_b = signed'(omc[32:1]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_go) prod_ff <= prod_in;
   end

   // Round to nearest, halves away from zero
   logic               sh16, neg;
   logic [63:0]        mag, rsum, shv, rneg;
   logic signed [31:0] rnd;

   always_comb begin
      sh16 = (cmd.mul_op == MOP_TX) || (cmd.mul_op == MOP_TY);
      neg  = prod_ff[63];
      mag  = neg ? 64'(-prod_ff) : 64'(prod_ff);
      rsum = mag + (sh16 ? (64'd1 << 15) : (64'd1 << 29));
      shv  = sh16 ? (rsum >> 16) : (rsum >> 30);
      rneg = neg ? -shv : shv;
      rnd  = signed'(rneg[31:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_wb) begin
         case (cmd.mul_op)
            MOP_CYC: cyc_ff <= sq_s - rnd;
            MOP_DX:  dx_ff <= rnd;
            MOP_DY:  dy_ff <= rnd;
            MOP_YD:  yd_ff <= rnd;
            MOP_TX:  tx_ff <= rnd;
            MOP_TY:  ty_ff <= rnd;
            default: lz_ff <= rnd;
         endcase
      end
   end

   // Final sums with saturation
   logic signed [23:0] x_sum, y_sum, z_sum;
   logic signed [23:0] x_sat, y_sat, z_sat;

   always_comb begin
      x_sum = 24'(leg_base_x(leg_ff)) + 24'(dx_ff) + 24'(tx_ff);
      y_sum = 24'(leg_base_y(leg_ff)) + 24'(dy_ff) + 24'(ty_ff);
      z_sum = 24'(sz_ff) + (cur_st ? 24'sd0 : 24'(lz_ff));
      x_sat = (x_sum > XY_MAX) ? XY_MAX : ((x_sum < XY_MIN) ? XY_MIN : x_sum);
      y_sat = (y_sum > XY_MAX) ? XY_MAX : ((y_sum < XY_MIN) ? XY_MIN : y_sum);
      z_sat = (z_sum > Z_MAX) ? Z_MAX : ((z_sum < Z_MIN) ? Z_MIN : z_sum);
   end

   // Result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         rsp_leg        <= leg_ff;
         rsp_foot_x     <= x_sat[18:0];
         rsp_foot_y     <= y_sat[18:0];
         rsp_foot_z     <= z_sat[19:0];
         rsp_in_stance  <= cur_st;
         rsp_all_stance <= all_ff;
         rsp_last       <= (leg_ff == LEG_W'(LEG_COUNT - 1));
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign status.div_done    = (cnt_ff == '0);
   assign status.rsp_pending = rsp_valid_ff;
   assign status.leg_last    = (leg_ff == LEG_W'(LEG_COUNT - 1));

endmodule
`default_nettype wire

### sv/trot_foot_trajectory_generator_unit.sv
`default_nettype none
// Trot foot trajectory generator. Each accepted request is one control tick and
// yields four results, one foot target per leg in order front-left, front-right,
// rear-left, rear-right, with last set on the fourth. The gait counter first
// goes through a 10-step divider to reduce it modulo the period, then each leg
// takes one divider pass for its TABLE_BITS-bit phase fraction, a quarter
// wave table read, and seven multiply-and-round operations on one shared
// 32 by 32 multiplier. A tick is lengthened while the result side holds
// rsp_stall. A new request is taken once the last leg of the previous tick has
// been delivered. The user must write the period and stance registers through
// the csr port only while no tick is in progress; the block itself does not
// enforce this.
module trot_foot_trajectory_generator_unit #(
   parameter int TABLE_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [0:0]         csr_index,
   input  wire logic [9:0]         csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_restart,
   input  wire logic signed [18:0] req_step_fwd,
   input  wire logic signed [16:0] req_step_lat,
   input  wire logic signed [16:0] req_yaw_amp,
   input  wire logic signed [19:0] req_stand_z,
   input  wire logic [16:0]        req_lift_h,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_leg,
   output logic signed [18:0]      rsp_foot_x,
   output logic signed [18:0]      rsp_foot_y,
   output logic signed [19:0]      rsp_foot_z,
   output logic                    rsp_in_stance,
   output logic                    rsp_all_stance,
   output logic                    rsp_last
);
   import tftg_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   tftg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage
   tftg_datapath #(
      .TABLE_BITS (TABLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_restart    (req_restart),
      .req_step_fwd   (req_step_fwd),
      .req_step_lat   (req_step_lat),
      .req_yaw_amp    (req_yaw_amp),
      .req_stand_z    (req_stand_z),
      .req_lift_h     (req_lift_h),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_leg        (rsp_leg),
      .rsp_foot_x     (rsp_foot_x),
      .rsp_foot_y     (rsp_foot_y),
      .rsp_foot_z     (rsp_foot_z),
      .rsp_in_stance  (rsp_in_stance),
      .rsp_all_stance (rsp_all_stance),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire
